@@ hdl/emc_pkg.sv @@
// ----------------------------------------------------------------------------
// emc_pkg
// Shared types and constants of the encoder move controller.
// ----------------------------------------------------------------------------
`default_nettype none

package emc_pkg;

    typedef enum logic [1:0] {
        CMD_SAMPLE  = 2'd0,
        CMD_FORWARD = 2'd1,
        CMD_ROTATE  = 2'd2,
        CMD_STOP    = 2'd3
    } t_cmd;

    localparam int unsigned ADDR_W = 3;

    // register select is the word address bit
    localparam logic REG_BASE_SPEED = 1'b0;
    localparam logic REG_SPEED_TRIM = 1'b1;

    localparam logic [7:0]        BASE_SPEED_RST = 8'd128;
    localparam logic signed [8:0] SPEED_TRIM_RST = 9'sd0;
    localparam logic signed [8:0] SPEED_MAX      = 9'sd255;
    localparam logic signed [8:0] SPEED_MIN      = -9'sd255;

    typedef struct packed {
        logic [7:0]        base_speed;
        logic signed [8:0] speed_trim;
    } t_cfg;

    typedef struct packed {
        t_cmd               cmd;
        logic               left_a;
        logic               left_b;
        logic               right_a;
        logic               right_b;
        logic signed [20:0] move_distance;
    } t_item;

    typedef struct packed {
        logic               last_left_a;
        logic               last_right_a;
        logic signed [31:0] left_count;
        logic signed [31:0] right_count;
        logic               moving;
        logic [21:0]        target_sum;
        logic signed [8:0]  left_speed;
        logic signed [8:0]  right_speed;
    } t_state;

    typedef struct packed {
        logic               left_dir1;
        logic               left_dir2;
        logic [7:0]         left_duty;
        logic               right_dir1;
        logic               right_dir2;
        logic [7:0]         right_duty;
        logic               busy_res;
        logic               done_res;
        logic signed [31:0] left_position;
        logic signed [31:0] right_position;
    } t_result;

endpackage

`default_nettype wire

@@ hdl/encoder_move_controller.sv @@
// ----------------------------------------------------------------------------
// encoder_move_controller
// Two-wheel move-by-count controller with x2 quadrature counting.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_ready) carries one request per sample of
// both encoders' pins, with a command: sample, start forward, start rotate,
// stop. Output channel (o_out_valid / i_out_ready) returns one result per
// request: bridge direction bits, PWM duties, busy, done and both counts.
// A request goes into the input register, one pass of logic updates the
// controller state and fills the result register: o_out_valid rises once the
// result register is loaded, and one request is taken every cycle while the
// receiver keeps up. When the receiver stalls, the result register holds; an
// empty input register still takes one more request, and o_in_ready stays
// low while the input register is full and the result is not taken.
// Reset clears counts, stops any move and zeroes both wheel speeds; base_speed
// returns to 128 and speed_trim to 0. Registers are written over the APB
// port: base_speed at 0x0, speed_trim at 0x4.
// ----------------------------------------------------------------------------
`default_nettype none

module encoder_move_controller (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              psel,
    input  wire                              penable,
    input  wire                              pwrite,
    input  wire [emc_pkg::ADDR_W-1:0]        paddr,
    input  wire [31:0]                       pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready,
    input  wire                              i_in_valid,
    output logic                             o_in_ready,
    input  wire [1:0]                        i_cmd,
    input  wire                              i_left_a,
    input  wire                              i_left_b,
    input  wire                              i_right_a,
    input  wire                              i_right_b,
    input  wire signed [20:0]                i_move_distance,
    output logic                             o_out_valid,
    input  wire                              i_out_ready,
    output logic                             o_left_dir1,
    output logic                             o_left_dir2,
    output logic [7:0]                       o_left_duty,
    output logic                             o_right_dir1,
    output logic                             o_right_dir2,
    output logic [7:0]                       o_right_duty,
    output logic                             o_busy_res,
    output logic                             o_done_res,
    output logic signed [31:0]               o_left_position,
    output logic signed [31:0]               o_right_position
);

    emc_pkg::t_cfg    r_cfg;
    logic             r_in_valid;
    emc_pkg::t_item   r_item;
    emc_pkg::t_state  r_state;
    emc_pkg::t_state  n_state;
    logic             r_out_valid;
    emc_pkg::t_result r_res;
    emc_pkg::t_result n_res;

    logic w_accept;
    logic w_advance;
    logic w_wr;

    // ---- configuration port
    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.base_speed <= emc_pkg::BASE_SPEED_RST;
            r_cfg.speed_trim <= emc_pkg::SPEED_TRIM_RST;
        end else if (w_wr) begin
            if (paddr[2] == emc_pkg::REG_SPEED_TRIM) begin
                r_cfg.speed_trim <= $signed(pwdata[8:0]);
            end else begin
                r_cfg.base_speed <= pwdata[7:0];
            end
        end
    end

    assign prdata = (paddr[2] == emc_pkg::REG_SPEED_TRIM)
                  ? {{23{r_cfg.speed_trim[8]}}, r_cfg.speed_trim}
                  : {24'd0, r_cfg.base_speed};

    // ---- request pipeline
    assign w_advance  = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_advance;
    assign w_accept   = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item.cmd           <= emc_pkg::t_cmd'(i_cmd);
            r_item.left_a        <= i_left_a;
            r_item.left_b        <= i_left_b;
            r_item.right_a       <= i_right_a;
            r_item.right_b       <= i_right_b;
            r_item.move_distance <= i_move_distance;
        end
    end

    emc_step u_step (
        .i_cfg    (r_cfg),
        .i_item   (r_item),
        .i_state  (r_state),
        .o_state  (n_state),
        .o_result (n_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= '0;
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_state     <= n_state;
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_res <= n_res;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_left_dir1      = r_res.left_dir1;
    assign o_left_dir2      = r_res.left_dir2;
    assign o_left_duty      = r_res.left_duty;
    assign o_right_dir1     = r_res.right_dir1;
    assign o_right_dir2     = r_res.right_dir2;
    assign o_right_duty     = r_res.right_duty;
    assign o_busy_res       = r_res.busy_res;
    assign o_done_res       = r_res.done_res;
    assign o_left_position  = r_res.left_position;
    assign o_right_position = r_res.right_position;

endmodule

`default_nettype wire

@@ hdl/emc_step.sv @@
// ----------------------------------------------------------------------------
// emc_step
// Next-state and result logic for one request: edge count, command, finish.
// ----------------------------------------------------------------------------
`default_nettype none

module emc_step (
    input  emc_pkg::t_cfg    i_cfg,
    input  emc_pkg::t_item   i_item,
    input  emc_pkg::t_state  i_state,
    output emc_pkg::t_state  o_state,
    output emc_pkg::t_result o_result
);

    localparam logic signed [9:0] SPEED_MAX_W = 10'(emc_pkg::SPEED_MAX);
    localparam logic signed [9:0] SPEED_MIN_W = 10'(emc_pkg::SPEED_MIN);

    function automatic logic signed [31:0] sat_step(input logic signed [31:0] v,
                                                   input logic up);
        logic signed [31:0] r;
        if (up) begin
            r = (v == 32'sh7FFF_FFFF) ? v : v + 32'sd1;
        end else begin
            r = (v == 32'sh8000_0000) ? v : v - 32'sd1;
        end
        return r;
    endfunction

    function automatic logic [31:0] mag32(input logic signed [31:0] v);
        return v[31] ? 32'(-v) : 32'(v);
    endfunction

    function automatic logic signed [8:0] clamp_speed(input logic signed [9:0] v);
        logic signed [8:0] r;
        if (v > SPEED_MAX_W) begin
            r = emc_pkg::SPEED_MAX;
        end else if (v < SPEED_MIN_W) begin
            r = emc_pkg::SPEED_MIN;
        end else begin
            r = v[8:0];
        end
        return r;
    endfunction

    logic signed [31:0] w_left_cnt;
    logic signed [31:0] w_right_cnt;
    logic signed [8:0]  w_base;
    logic signed [9:0]  w_trimmed;
    logic               w_dist_pos;
    logic [20:0]        w_dist_mag;
    logic [32:0]        w_sum;
    logic               w_done;
    emc_pkg::t_state    w_st;

    assign w_base     = $signed({1'b0, i_cfg.base_speed});
    assign w_trimmed  = $signed({2'b00, i_cfg.base_speed})
                      + $signed({i_cfg.speed_trim[8], i_cfg.speed_trim});
    assign w_dist_pos = !i_item.move_distance[20] && (i_item.move_distance != 21'sd0);
    assign w_dist_mag = i_item.move_distance[20] ? 21'(-i_item.move_distance)
                                                 : 21'(i_item.move_distance);

    assign w_left_cnt  = (i_item.left_a != i_state.last_left_a)
                       ? sat_step(i_state.left_count, i_item.left_a != i_item.left_b)
                       : i_state.left_count;
    assign w_right_cnt = (i_item.right_a != i_state.last_right_a)
                       ? sat_step(i_state.right_count, i_item.right_a == i_item.right_b)
                       : i_state.right_count;

    always_comb begin
        w_st              = i_state;
        w_st.last_left_a  = i_item.left_a;
        w_st.last_right_a = i_item.right_a;
        w_st.left_count   = w_left_cnt;
        w_st.right_count  = w_right_cnt;
        case (i_item.cmd)
            emc_pkg::CMD_FORWARD: begin
                w_st.left_count  = '0;
                w_st.right_count = '0;
                w_st.moving      = 1'b1;
                w_st.target_sum  = w_dist_pos ? {1'b0, i_item.move_distance[19:0], 1'b0}
                                              : 22'd0;
                w_st.left_speed  = w_base;
                w_st.right_speed = clamp_speed(w_trimmed);
            end
            emc_pkg::CMD_ROTATE: begin
                w_st.left_count  = '0;
                w_st.right_count = '0;
                w_st.moving      = 1'b1;
                w_st.target_sum  = {w_dist_mag, 1'b0};
                w_st.left_speed  = w_dist_pos ? -w_base : w_base;
                w_st.right_speed = w_dist_pos ? w_base : -w_base;
            end
            emc_pkg::CMD_STOP: begin
                w_st.moving      = 1'b0;
                w_st.left_speed  = '0;
                w_st.right_speed = '0;
            end
            default: begin
            end
        endcase
    end

    assign w_sum  = {1'b0, mag32(w_st.left_count)} + {1'b0, mag32(w_st.right_count)};
    assign w_done = w_st.moving && (w_sum >= {11'd0, w_st.target_sum});

    always_comb begin
        o_state = w_st;
        if (w_done) begin
            // finish: brake both wheels
            o_state.moving      = 1'b0;
            o_state.left_speed  = '0;
            o_state.right_speed = '0;
        end
    end

    always_comb begin
        o_result.left_dir1      = !(o_state.left_speed > 9'sd0);
        o_result.left_dir2      = !o_state.left_speed[8];
        o_result.left_duty      = o_state.left_speed[8] ? 8'(-o_state.left_speed)
                                                        : o_state.left_speed[7:0];
        o_result.right_dir1     = !o_state.right_speed[8];
        o_result.right_dir2     = !(o_state.right_speed > 9'sd0);
        o_result.right_duty     = o_state.right_speed[8] ? 8'(-o_state.right_speed)
                                                         : o_state.right_speed[7:0];
        o_result.busy_res       = o_state.moving;
        o_result.done_res       = w_done;
        o_result.left_position  = o_state.left_count;
        o_result.right_position = o_state.right_count;
    end

endmodule

`default_nettype wire

@@ hdl/emc_checker.sv @@
// ----------------------------------------------------------------------------
// emc_checker
// Port-level checks of the encoder move controller, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module emc_checker (
    input wire               i_clk,
    input wire               i_rst_n,
    input wire               o_out_valid,
    input wire               i_out_ready,
    input wire               o_left_dir1,
    input wire               o_left_dir2,
    input wire [7:0]         o_left_duty,
    input wire               o_right_dir1,
    input wire               o_right_dir2,
    input wire [7:0]         o_right_duty,
    input wire               o_busy_res,
    input wire               o_done_res,
    input wire signed [31:0] o_left_position,
    input wire signed [31:0] o_right_position
);

    logic w_braked;
    assign w_braked = o_left_dir1 && o_left_dir2 && o_right_dir1 && o_right_dir2
                   && (o_left_duty == 8'd0) && (o_right_duty == 8'd0);

    // a finished move is no longer busy
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_done_res) |-> !o_busy_res)
        else $error("done result still busy");

    // without a move both wheels are braked
    a_idle_brake: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_busy_res) |-> w_braked)
        else $error("wheels driven while no move is active");

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_left_position)
            && $stable(o_right_position) && $stable(o_done_res) && $stable(o_busy_res)))
        else $error("stalled result changed");

    // nothing is offered right after reset
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind encoder_move_controller emc_checker u_emc_checker (.*);

`default_nettype wire

@@ dv/encoder_move_controller_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// encoder_move_controller_test
// Drives sample and move requests through the valid/ready channels with
// random gaps and output stalls. Each request is predicted by a scoreboard
// that tracks counts, move state and wheel speeds, and every result is checked
// field by field. Speed registers are rewritten over APB between phases.
// ----------------------------------------------------------------------------

module encoder_move_controller_test;

    localparam logic [emc_pkg::ADDR_W-1:0] ADDR_BASE_SPEED = {emc_pkg::REG_BASE_SPEED, 2'b00};
    localparam logic [emc_pkg::ADDR_W-1:0] ADDR_SPEED_TRIM = {emc_pkg::REG_SPEED_TRIM, 2'b00};
    localparam int WATCHDOG_LIMIT = 500;
    localparam int SETTLE_CYCLES  = 4;
    localparam int PHASE_ITEMS    = 170;

    class move_scoreboard;
        logic [7:0]        base_speed;
        logic signed [8:0] speed_trim;
        logic              last_la;
        logic              last_ra;
        logic signed [31:0] lcnt;
        logic signed [31:0] rcnt;
        bit                moving;
        logic [21:0]       target;
        int                lspd;
        int                rspd;
        emc_pkg::t_result  expected_q[$];
        int                errors;
        int                n_checked;

        function new();
            base_speed = emc_pkg::BASE_SPEED_RST;
            speed_trim = emc_pkg::SPEED_TRIM_RST;
            last_la    = 1'b0;
            last_ra    = 1'b0;
            lcnt       = '0;
            rcnt       = '0;
            moving     = 1'b0;
            target     = '0;
            lspd       = 0;
            rspd       = 0;
            errors     = 0;
            n_checked  = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void set_config(logic [emc_pkg::ADDR_W-1:0] addr, logic [31:0] data);
            if (addr == ADDR_BASE_SPEED) begin
                base_speed = data[7:0];
            end else if (addr == ADDR_SPEED_TRIM) begin
                speed_trim = data[8:0];
            end
        endfunction

        function logic signed [31:0] bump(logic signed [31:0] v, bit up);
            if (up) begin
                return (v == 32'sh7fffffff) ? v : v + 32'sd1;
            end
            return (v == 32'sh80000000) ? v : v - 32'sd1;
        endfunction

        function int clamp(int v);
            if (v > 255) return 255;
            if (v < -255) return -255;
            return v;
        endfunction

        function longint mag(longint v);
            return (v < 0) ? -v : v;
        endfunction

        function void note_request(emc_pkg::t_item it);
            emc_pkg::t_result r;
            bit      done;
            int      mv_dist;
            done = 1'b0;
            mv_dist = int'(it.move_distance);
            // count edges before the command, so a start clears them
            if (it.left_a != last_la) lcnt = bump(lcnt, it.left_a != it.left_b);
            if (it.right_a != last_ra) rcnt = bump(rcnt, it.right_a == it.right_b);
            last_la = it.left_a;
            last_ra = it.right_a;
            case (it.cmd)
                emc_pkg::CMD_FORWARD: begin
                    lcnt   = '0;
                    rcnt   = '0;
                    moving = 1'b1;
                    target = (mv_dist > 0) ? 22'(2 * longint'(mv_dist)) : '0;
                    lspd   = clamp(int'(base_speed));
                    rspd   = clamp(int'(base_speed) + int'(speed_trim));
                end
                emc_pkg::CMD_ROTATE: begin
                    lcnt   = '0;
                    rcnt   = '0;
                    moving = 1'b1;
                    target = 22'(2 * mag(mv_dist));
                    if (mv_dist > 0) begin
                        lspd = -int'(base_speed);
                        rspd = int'(base_speed);
                    end else begin
                        lspd = int'(base_speed);
                        rspd = -int'(base_speed);
                    end
                end
                emc_pkg::CMD_STOP: begin
                    moving = 1'b0;
                    lspd   = 0;
                    rspd   = 0;
                end
                default: ;
            endcase
            if (moving && mag(lcnt) + mag(rcnt) >= longint'(target)) begin
                moving = 1'b0;
                lspd   = 0;
                rspd   = 0;
                done   = 1'b1;
            end
            r.left_dir1      = !(lspd > 0);
            r.left_dir2      = !(lspd < 0);
            r.left_duty      = 8'(mag(lspd));
            r.right_dir1     = !(rspd < 0);
            r.right_dir2     = !(rspd > 0);
            r.right_duty     = 8'(mag(rspd));
            r.busy_res       = moving;
            r.done_res       = done;
            r.left_position  = lcnt;
            r.right_position = rcnt;
            expected_q.push_back(r);
        endfunction

        task report_mismatch(string msg);
            $display("[%0t] mismatch on result %0d: %s", $time, n_checked, msg);
            errors++;
        endtask

        task check_result(emc_pkg::t_result got);
            emc_pkg::t_result want;
            if (expected_q.size() == 0) begin
                report_mismatch("result with no request pending");
            end else begin
                want = expected_q.pop_front();
                if (got.left_dir1 !== want.left_dir1)
                    report_mismatch($sformatf("left_dir1 got %0b want %0b",
                                              got.left_dir1, want.left_dir1));
                if (got.left_dir2 !== want.left_dir2)
                    report_mismatch($sformatf("left_dir2 got %0b want %0b",
                                              got.left_dir2, want.left_dir2));
                if (got.left_duty !== want.left_duty)
                    report_mismatch($sformatf("left_duty got %0d want %0d",
                                              got.left_duty, want.left_duty));
                if (got.right_dir1 !== want.right_dir1)
                    report_mismatch($sformatf("right_dir1 got %0b want %0b",
                                              got.right_dir1, want.right_dir1));
                if (got.right_dir2 !== want.right_dir2)
                    report_mismatch($sformatf("right_dir2 got %0b want %0b",
                                              got.right_dir2, want.right_dir2));
                if (got.right_duty !== want.right_duty)
                    report_mismatch($sformatf("right_duty got %0d want %0d",
                                              got.right_duty, want.right_duty));
                if (got.busy_res !== want.busy_res)
                    report_mismatch($sformatf("busy_res got %0b want %0b",
                                              got.busy_res, want.busy_res));
                if (got.done_res !== want.done_res)
                    report_mismatch($sformatf("done_res got %0b want %0b",
                                              got.done_res, want.done_res));
                if (got.left_position !== want.left_position)
                    report_mismatch($sformatf("left_position got %0d want %0d",
                                              got.left_position, want.left_position));
                if (got.right_position !== want.right_position)
                    report_mismatch($sformatf("right_position got %0d want %0d",
                                              got.right_position, want.right_position));
            end
            n_checked++;
        endtask
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [emc_pkg::ADDR_W-1:0] paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic [1:0]         i_cmd = emc_pkg::CMD_SAMPLE;
    logic               i_left_a = 1'b0;
    logic               i_left_b = 1'b0;
    logic               i_right_a = 1'b0;
    logic               i_right_b = 1'b0;
    logic signed [20:0] i_move_distance = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic               o_left_dir1;
    logic               o_left_dir2;
    logic [7:0]         o_left_duty;
    logic               o_right_dir1;
    logic               o_right_dir2;
    logic [7:0]         o_right_duty;
    logic               o_busy_res;
    logic               o_done_res;
    logic signed [31:0] o_left_position;
    logic signed [31:0] o_right_position;

    move_scoreboard sb = new();

    bit       idle_en = 1'b0;
    bit       quiet_tail = 1'b0;
    int       out_stall = 0;
    int       quiet_cycles = 0;
    logic [1:0] phase_l = '0;
    logic [1:0] phase_r = '0;
    bit       fwd_l = 1'b1;
    bit       fwd_r = 1'b1;

    encoder_move_controller dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_cmd            (i_cmd),
        .i_left_a         (i_left_a),
        .i_left_b         (i_left_b),
        .i_right_a        (i_right_a),
        .i_right_b        (i_right_b),
        .i_move_distance  (i_move_distance),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_left_dir1      (o_left_dir1),
        .o_left_dir2      (o_left_dir2),
        .o_left_duty      (o_left_duty),
        .o_right_dir1     (o_right_dir1),
        .o_right_dir2     (o_right_dir2),
        .o_right_duty     (o_right_duty),
        .o_busy_res       (o_busy_res),
        .o_done_res       (o_done_res),
        .o_left_position  (o_left_position),
        .o_right_position (o_right_position)
    );

    always #1 i_clk = ~i_clk;

    // receiver: stall in random bursts while idling is enabled
    always @(negedge i_clk) begin
        if (out_stall > 0) begin
            out_stall--;
            i_out_ready <= 1'b0;
        end else if (idle_en && $urandom_range(0, 5) == 0) begin
            out_stall = $urandom_range(1, 3) - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        emc_pkg::t_item   req;
        emc_pkg::t_result res;
        bit      active;
        if (i_rst_n) begin
            active = 1'b0;
            if (i_in_valid && o_in_ready) begin
                req.cmd           = emc_pkg::t_cmd'(i_cmd);
                req.left_a        = i_left_a;
                req.left_b        = i_left_b;
                req.right_a       = i_right_a;
                req.right_b       = i_right_b;
                req.move_distance = i_move_distance;
                sb.note_request(req);
                active = 1'b1;
            end
            if (o_out_valid && i_out_ready) begin
                res.left_dir1      = o_left_dir1;
                res.left_dir2      = o_left_dir2;
                res.left_duty      = o_left_duty;
                res.right_dir1     = o_right_dir1;
                res.right_dir2     = o_right_dir2;
                res.right_duty     = o_right_duty;
                res.busy_res       = o_busy_res;
                res.done_res       = o_done_res;
                res.left_position  = o_left_position;
                res.right_position = o_right_position;
                sb.check_result(res);
                active = 1'b1;
            end
            if (psel && penable && pready) active = 1'b1;
            quiet_cycles = active ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
                $display("encoder_move_controller_test: FAIL");
                $finish;
            end
        end
    end

    task send_request(emc_pkg::t_item it);
        @(negedge i_clk);
        if (idle_en && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_cmd           <= it.cmd;
        i_left_a        <= it.left_a;
        i_left_b        <= it.left_b;
        i_right_a       <= it.right_a;
        i_right_b       <= it.right_b;
        i_move_distance <= it.move_distance;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task send_fields(emc_pkg::t_cmd c, logic la, logic lb, logic ra, logic rb, int mv_dist);
        emc_pkg::t_item it;
        it.cmd           = c;
        it.left_a        = la;
        it.left_b        = lb;
        it.right_a       = ra;
        it.right_b       = rb;
        it.move_distance = 21'(mv_dist);
        send_request(it);
    endtask

    // hold the input side until every result is back, then let the block settle
    task drain_results();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (sb.pending() > 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task apb_write(logic [emc_pkg::ADDR_W-1:0] addr, logic [31:0] data);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.set_config(addr, data);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    function logic [1:0] step_phase(logic [1:0] ph, bit fwd);
        int r;
        r = $urandom_range(0, 9);
        if (r < 7) return fwd ? ph + 2'd1 : ph - 2'd1;
        if (r == 7) return fwd ? ph - 2'd1 : ph + 2'd1;
        return ph;
    endfunction

    function int move_distance_pick(bit rotate);
        if ($urandom_range(0, 9) == 0) return int'($signed(21'($urandom)));
        return rotate ? $urandom_range(0, 24) - 12 : $urandom_range(0, 16) - 4;
    endfunction

    // mostly quadrature walks inside moves, with some noise
    function emc_pkg::t_item random_request();
        emc_pkg::t_item it;
        int    r;
        r = $urandom_range(0, 99);
        if (r < 4) begin
            it.cmd           = emc_pkg::t_cmd'($urandom_range(0, 3));
            it.left_a        = $urandom_range(0, 1);
            it.left_b        = $urandom_range(0, 1);
            it.right_a       = $urandom_range(0, 1);
            it.right_b       = $urandom_range(0, 1);
            it.move_distance = 21'($urandom);
            return it;
        end
        phase_l = step_phase(phase_l, fwd_l);
        phase_r = step_phase(phase_r, fwd_r);
        it.left_a        = phase_l[1];
        it.left_b        = phase_l[1] ^ phase_l[0];
        it.right_a       = phase_r[1];
        it.right_b       = phase_r[1] ^ phase_r[0];
        it.move_distance = 21'($urandom);
        it.cmd           = emc_pkg::CMD_SAMPLE;
        if (r < 9) begin
            it.cmd           = emc_pkg::CMD_FORWARD;
            it.move_distance = 21'(move_distance_pick(1'b0));
        end else if (r < 13) begin
            it.cmd           = emc_pkg::CMD_ROTATE;
            it.move_distance = 21'(move_distance_pick(1'b1));
        end else if (r < 15) begin
            it.cmd = emc_pkg::CMD_STOP;
        end
        if (it.cmd == emc_pkg::CMD_FORWARD || it.cmd == emc_pkg::CMD_ROTATE) begin
            fwd_l = $urandom_range(0, 1);
            fwd_r = $urandom_range(0, 1);
        end
        return it;
    endfunction

    task run_random(int n_items);
        for (int k = 0; k < n_items; k++) begin
            if (k % 30 == 0) idle_en = !quiet_tail && ($urandom_range(0, 3) != 0);
            if (k == n_items / 2 && !quiet_tail) drain_results();
            send_request(random_request());
        end
    endtask

    task run_directed();
        send_fields(emc_pkg::CMD_SAMPLE,  0, 0, 0, 0, 0);
        send_fields(emc_pkg::CMD_SAMPLE,  1, 0, 1, 1, -1048576);
        send_fields(emc_pkg::CMD_SAMPLE,  0, 0, 0, 1, 1048575);
        // non-positive forward distances finish on the command itself
        send_fields(emc_pkg::CMD_FORWARD, 0, 0, 0, 1, 0);
        send_fields(emc_pkg::CMD_FORWARD, 0, 0, 0, 1, -5);
        send_fields(emc_pkg::CMD_FORWARD, 0, 0, 0, 1, 2);
        send_fields(emc_pkg::CMD_SAMPLE,  1, 0, 1, 1, 0);
        send_fields(emc_pkg::CMD_SAMPLE,  0, 1, 0, 0, 0);
        // edge on the start item is counted, then cleared
        send_fields(emc_pkg::CMD_FORWARD, 1, 1, 1, 0, 1048575);
        send_fields(emc_pkg::CMD_ROTATE,  1, 1, 1, 0, 3);
        send_fields(emc_pkg::CMD_SAMPLE,  0, 0, 0, 1, 0);
        send_fields(emc_pkg::CMD_STOP,    0, 0, 0, 1, 0);
        send_fields(emc_pkg::CMD_SAMPLE,  1, 1, 1, 1, 0);
        send_fields(emc_pkg::CMD_ROTATE,  1, 1, 1, 1, -1048576);
        send_fields(emc_pkg::CMD_ROTATE,  1, 1, 1, 1, 0);
        send_fields(emc_pkg::CMD_ROTATE,  1, 1, 1, 1, -2);
        send_fields(emc_pkg::CMD_SAMPLE,  0, 1, 0, 0, 0);
        send_fields(emc_pkg::CMD_SAMPLE,  1, 0, 1, 1, 0);
        send_fields(emc_pkg::CMD_SAMPLE,  0, 1, 0, 0, 0);
        send_fields(emc_pkg::CMD_SAMPLE,  1, 0, 1, 1, 0);
        send_fields(emc_pkg::CMD_STOP,    1, 0, 1, 1, 0);
        send_fields(emc_pkg::CMD_FORWARD, 0, 0, 0, 0, 1);
        send_fields(emc_pkg::CMD_SAMPLE,  1, 0, 1, 1, 0);
    endtask

    initial begin
        logic [7:0]        next_base;
        logic signed [8:0] next_trim;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        run_directed();
        idle_en = 1'b1;
        run_random(PHASE_ITEMS);
        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin next_base = 8'd255; next_trim = emc_pkg::SPEED_MAX; end
                1: begin next_base = 8'd0;   next_trim = emc_pkg::SPEED_MIN; end
                2: begin next_base = 8'd255; next_trim = emc_pkg::SPEED_MIN; end
                default: begin
                    next_base = $urandom_range(0, 255);
                    next_trim = 9'($urandom_range(0, 510) - 255);
                end
            endcase
            drain_results();
            apb_write(ADDR_BASE_SPEED, 32'(next_base));
            apb_write(ADDR_SPEED_TRIM, 32'(next_trim));
            // no idling in the last part of the run
            if (p == 3) quiet_tail = 1'b1;
            run_random(PHASE_ITEMS);
        end
        drain_results();
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("encoder_move_controller_test: PASS");
        end else begin
            $display("encoder_move_controller_test: FAIL");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/emc_pkg.sv
hdl/emc_step.sv
hdl/encoder_move_controller.sv
hdl/emc_checker.sv
dv/encoder_move_controller_test.sv
